>>> src/tng_pkg.sv
// ----------------------------------------------------------------------------
// tng_pkg: shared types and constants of the name generator
// Request and result payloads, component constants and the symbol alphabet.
// ----------------------------------------------------------------------------
package tng_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned DIGIT_W = 5;
   localparam int unsigned N_COMP  = 4;
   localparam int unsigned N_CHAR  = 6;

   typedef enum logic {
      REQ_SEED     = 1'b0,
      REQ_GENERATE = 1'b1
   } tng_kind_type;

   typedef struct packed {
      tng_kind_type        req_type;
      logic [WORD_W-1:0]   seed_time;
   } tng_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   rand_word;
      logic [CHAR_W-1:0]   char_0;
      logic [CHAR_W-1:0]   char_1;
      logic [CHAR_W-1:0]   char_2;
      logic [CHAR_W-1:0]   char_3;
      logic [CHAR_W-1:0]   char_4;
      logic [CHAR_W-1:0]   char_5;
   } tng_rsp_type;

   typedef logic [N_COMP-1:0][WORD_W-1:0] tng_state_type;

   // Per-component step constants.
   localparam logic [WORD_W-1:0] KEEP_MASK [N_COMP] =
      '{32'hFFFF_FFFE, 32'hFFFF_FFF8, 32'hFFFF_FFF0, 32'hFFFF_FF80};
   localparam logic [4:0] SHIFT_KEEP [N_COMP] = '{5'd18, 5'd2, 5'd7, 5'd13};
   localparam logic [4:0] SHIFT_FB   [N_COMP] = '{5'd6, 5'd2, 5'd13, 5'd3};
   localparam logic [4:0] SHIFT_OUT  [N_COMP] = '{5'd13, 5'd27, 5'd21, 5'd12};

   // Seed constants.
   localparam logic [WORD_W-1:0] SEED_KEY [N_COMP] =
      '{32'd2421089565, 32'd3453830001, 32'd1437919543, 32'd1406684125};
   localparam logic [WORD_W-1:0] FLOOR_VAL [N_COMP] =
      '{32'd1, 32'd7, 32'd15, 32'd127};

   // "0123456789ABCDEFGHJKMNPQRSTUVWYZ" as ASCII codes.
   localparam logic [CHAR_W-1:0] ALPHABET [2**DIGIT_W] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70,
      7'd71, 7'd72, 7'd74, 7'd75, 7'd77, 7'd78, 7'd80, 7'd81,
      7'd82, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd89, 7'd90
   };

endpackage

>>> src/tng_advance.sv
// ----------------------------------------------------------------------------
// tng_advance: next-state logic of the four generator components
// Seed perturbation or one Tausworthe step per component, plus the XOR word.
// ----------------------------------------------------------------------------
module tng_advance
   import tng_pkg::*;
(
   input  tng_state_type       state,
   input  tng_req_type         req,
   output tng_state_type       state_next,
   output logic [WORD_W-1:0]   rand_word
);

   tng_state_type stepped;
   tng_state_type seeded;

   for (genvar c = 0; c < N_COMP; c++) begin : g_comp
      logic [WORD_W-1:0] kept;
      logic [WORD_W-1:0] fb;
      logic [WORD_W-1:0] sum;

      always_comb begin
         kept = (state[c] & KEEP_MASK[c]) << SHIFT_KEEP[c];
         fb   = ((state[c] << SHIFT_FB[c]) ^ state[c]) >> SHIFT_OUT[c];
         stepped[c] = kept ^ fb;

         // wrap the add, then lift a word below its floor
         sum = state[c] + (req.seed_time ^ SEED_KEY[c]);
         if (sum < FLOOR_VAL[c]) begin
            seeded[c] = sum + FLOOR_VAL[c];
         end else begin
            seeded[c] = sum;
         end
      end
   end

   assign state_next = (req.req_type == REQ_GENERATE) ? stepped : seeded;
   assign rand_word  = stepped[0] ^ stepped[1] ^ stepped[2] ^ stepped[3];

endmodule

>>> src/tng_encode.sv
// ----------------------------------------------------------------------------
// tng_encode: name character encoder
// Look up six 5-bit digits of the word, least significant first.
// ----------------------------------------------------------------------------
module tng_encode
   import tng_pkg::*;
(
   input  logic [WORD_W-1:0]   rand_word,
   output tng_rsp_type         rsp
);

   logic [N_CHAR-1:0][CHAR_W-1:0] chars;

   for (genvar i = 0; i < N_CHAR; i++) begin : g_char
      assign chars[i] = ALPHABET[rand_word[i*DIGIT_W +: DIGIT_W]];
   end

   always_comb begin
      rsp.rand_word = rand_word;
      rsp.char_0    = chars[0];
      rsp.char_1    = chars[1];
      rsp.char_2    = chars[2];
      rsp.char_3    = chars[3];
      rsp.char_4    = chars[4];
      rsp.char_5    = chars[5];
   end

endmodule

>>> src/tausworthe_name_generator_core.sv
// ----------------------------------------------------------------------------
// tausworthe_name_generator_core: combined LFSR113 generator with name encoder
// Seed and generate requests in, random word and six name characters out.
// ----------------------------------------------------------------------------
// The block holds the four 32-bit components of a combined four-component
// Tausworthe generator. A seed request adds its time value, XORed with a
// per-component key, into each component and lifts any component below its
// floor (1, 7, 15, 127); it returns nothing. A generate request advances all
// four components one step and returns their XOR together with six ASCII
// name characters, one per 5-bit digit taken from the low end. Components
// reset to zero, so software must seed before generating; until then every
// result is zero with all characters '0'. A request is taken every clock
// while the output register is empty or being drained; the component update
// and character lookup complete in the cycle of the request, and the result
// sits in one output register, refilled in the same cycle it is taken.
module tausworthe_name_generator_core
   import tng_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  tng_req_type   req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output tng_rsp_type   rsp_data
);

   tng_state_type       state_ff;
   tng_state_type       state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   tng_rsp_type         rsp_ff;
   tng_rsp_type         rsp_in;
   logic [WORD_W-1:0]   word;
   logic                req_fire;
   logic                gen_fire;

   // Next component values and the XOR word for the current request.
   tng_advance u_advance (
      .state      (state_ff),
      .req        (req_data),
      .state_next (state_in),
      .rand_word  (word)
   );

   // Character lookup on the fresh word.
   tng_encode u_encode (
      .rand_word (word),
      .rsp       (rsp_in)
   );

   // Accept whenever the output register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign gen_fire  = req_fire && (req_data.req_type == REQ_GENERATE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (gen_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Components: clear on reset, update on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Result payload: load only on a generate request.
   always_ff @(posedge clock) begin
      if (gen_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the Tausworthe name generator core
// Drives seed and generate requests with random bursts and gaps, stalls the
// result side on its own pattern, and checks every result field against an
// independent model of the four-component generator and its name encoder.
// ----------------------------------------------------------------------------
import tng_pkg::*;

// Independent model of the generator state plus the queue of words and
// characters still owed by the block.
class name_word_scoreboard;
   logic [31:0] comp_words [4];
   logic [31:0] seed_keys [4];
   logic [31:0] floors [4];
   string       symbols;
   tng_rsp_type expected_words [$];
   int unsigned fail_count;

   function new();
      seed_keys = '{32'd2421089565, 32'd3453830001, 32'd1437919543, 32'd1406684125};
      floors    = '{32'd1, 32'd7, 32'd15, 32'd127};
      symbols   = "0123456789ABCDEFGHJKMNPQRSTUVWYZ";
      for (int k = 0; k < 4; k++) comp_words[k] = '0;
      fail_count = 0;
   endfunction

   // One step of one component; all arithmetic stays in 32 bits.
   function logic [31:0] taus_advance(logic [31:0] w, logic [31:0] keep,
                                      int sh_keep, int sh_fb, int sh_out);
      return ((w & keep) << sh_keep) ^ (((w << sh_fb) ^ w) >> sh_out);
   endfunction

   function logic [6:0] symbol_of(logic [4:0] digit);
      byte c;
      c = symbols[digit];
      return c[6:0];
   endfunction

   // Time value that makes the sum for component k equal target on the next seed request.
   function logic [31:0] seed_for(int k, logic [31:0] target);
      return (target - comp_words[k]) ^ seed_keys[k];
   endfunction

   function int unsigned outstanding();
      return expected_words.size();
   endfunction

   function void note_request(tng_req_type req);
      logic [31:0] sum;
      logic [31:0] word;
      tng_rsp_type want;
      if (req.req_type == REQ_SEED) begin
         for (int k = 0; k < 4; k++) begin
            sum = comp_words[k] + (req.seed_time ^ seed_keys[k]);
            if (sum < floors[k]) sum = sum + floors[k];
            comp_words[k] = sum;
         end
      end else begin
         comp_words[0] = taus_advance(comp_words[0], 32'hFFFF_FFFE, 18, 6, 13);
         comp_words[1] = taus_advance(comp_words[1], 32'hFFFF_FFF8, 2, 2, 27);
         comp_words[2] = taus_advance(comp_words[2], 32'hFFFF_FFF0, 7, 13, 21);
         comp_words[3] = taus_advance(comp_words[3], 32'hFFFF_FF80, 13, 3, 12);
         word = comp_words[0] ^ comp_words[1] ^ comp_words[2] ^ comp_words[3];
         want.rand_word = word;
         want.char_0 = symbol_of(word[4:0]);
         want.char_1 = symbol_of(word[9:5]);
         want.char_2 = symbol_of(word[14:10]);
         want.char_3 = symbol_of(word[19:15]);
         want.char_4 = symbol_of(word[24:20]);
         want.char_5 = symbol_of(word[29:25]);
         expected_words.push_back(want);
      end
   endfunction

   task report(string what);
      fail_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task check_result(tng_rsp_type got);
      tng_rsp_type want;
      if (expected_words.size() == 0) begin
         report($sformatf("result %h with nothing expected", got.rand_word));
         return;
      end
      want = expected_words.pop_front();
      compare_field("rand_word", got.rand_word, want.rand_word);
      compare_field("char_0", 32'(got.char_0), 32'(want.char_0));
      compare_field("char_1", 32'(got.char_1), 32'(want.char_1));
      compare_field("char_2", 32'(got.char_2), 32'(want.char_2));
      compare_field("char_3", 32'(got.char_3), 32'(want.char_3));
      compare_field("char_4", 32'(got.char_4), 32'(want.char_4));
      compare_field("char_5", 32'(got.char_5), 32'(want.char_5));
   endtask
endclass

module tb_top;

   localparam int NO_AIM       = -1;
   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD    = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tng_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tng_rsp_type rsp_data;

   name_word_scoreboard board = new();

   tausworthe_name_generator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs a channel.
   initial begin
      #3_200_000;
      $display("== FAIL ==");
      $finish;
   end

   // Sample both channels at the rising edge. A request is noted before the
   // result of the same edge is checked; the result is registered, so the
   // order only matters if the block were to answer combinationally.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   // Offer one request and hold it until the block takes it. With aim_comp
   // set, the time value is worked out at the falling edge from the model
   // state, so that the chosen component's sum lands exactly on aim_value.
   task automatic offer(input tng_kind_type kind, input logic [31:0] t,
                        input int aim_comp, input logic [31:0] aim_value);
      logic [31:0] value;
      value = t;
      @(negedge clock);
      if (aim_comp != NO_AIM) value = board.seed_for(aim_comp, aim_value);
      req_data.req_type  <= kind;
      req_data.seed_time <= value;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid over a pause of length n and put noise on the idle payload.
   task automatic pause_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid          <= 1'b0;
         req_data.req_type  <= tng_kind_type'($urandom_range(0, 1));
         req_data.seed_time <= $urandom;
      end
   endtask

   // Result side: stall in segments of random mode and length. Once, partway
   // through, hold off with rsp_ready low for LONG_HOLD so the output fills
   // and the block must stall its request side.
   initial begin : receiver
      int unsigned rx_cycles;
      int unsigned mode;
      int unsigned seg_len;
      bit          long_hold_done;
      rx_cycles      = 0;
      long_hold_done = 1'b0;
      rsp_ready      = 1'b0;
      forever begin
         if (!long_hold_done && rx_cycles >= 400) begin
            long_hold_done = 1'b1;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
               rx_cycles++;
            end
         end else begin
            mode    = $urandom_range(0, 9);
            seg_len = $urandom_range(10, 60);
            repeat (seg_len) begin
               @(negedge clock);
               case (mode) inside
                  [0:3]:   rsp_ready <= 1'b1;
                  [4:6]:   rsp_ready <= 1'($urandom_range(0, 1));
                  7:       rsp_ready <= (rx_cycles % 3 != 0);
                  8:       rsp_ready <= ($urandom_range(0, 7) == 0);
                  default: rsp_ready <= 1'b0;
               endcase
               rx_cycles++;
            end
         end
      end
   end

   initial begin : sender
      int          items;
      int          burst_left;
      int          gap;
      int          sel;
      int          k;
      logic [31:0] pick;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Generate before any seed: state stays zero, all characters '0'.
      offer(REQ_GENERATE, 32'h0000_0000, NO_AIM, '0);
      offer(REQ_GENERATE, 32'hFFFF_FFFF, NO_AIM, '0);
      // Seeds that drop a component to zero or just under its floor, so it
      // gets lifted, and one that lands exactly on the floor.
      offer(REQ_SEED, '0, 0, 32'd0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      offer(REQ_SEED, '0, 1, 32'd6);
      offer(REQ_SEED, '0, 2, 32'd15);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      offer(REQ_SEED, '0, 3, 32'd0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      offer(REQ_SEED, '0, 3, 32'd126);
      offer(REQ_GENERATE, 32'hFFFF_FFFF, NO_AIM, '0);
      // Field extremes; all ones also wraps the additions.
      offer(REQ_SEED, 32'hFFFF_FFFF, NO_AIM, '0);
      offer(REQ_GENERATE, 32'h0000_0000, NO_AIM, '0);
      offer(REQ_SEED, 32'h0000_0000, NO_AIM, '0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      // Wrap to just below the floor from a large component value.
      offer(REQ_SEED, '0, 2, 32'd14);
      offer(REQ_SEED, '0, 1, 32'hFFFF_FFFF);
      offer(REQ_SEED, '0, 1, 32'd0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);
      offer(REQ_GENERATE, $urandom, NO_AIM, '0);

      // Random part: mostly generates between seeds, in bursts with gaps.
      items      = 0;
      burst_left = 0;
      while (items < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) pause_sender(gap);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
         end
         sel = $urandom_range(0, 99);
         k   = $urandom_range(0, 3);
         if (sel < 70) begin
            offer(REQ_GENERATE, $urandom, NO_AIM, '0);
         end else if (sel < 80) begin
            offer(REQ_SEED, $urandom, NO_AIM, '0);
         end else if (sel < 90) begin
            // land one component in or just above its lifted range
            offer(REQ_SEED, '0, k, $urandom_range(0, 2 * board.floors[k]));
         end else if (sel < 95) begin
            case ($urandom_range(0, 2))
               0:       pick = 32'h0000_0000;
               1:       pick = 32'hFFFF_FFFF;
               default: pick = board.seed_keys[k];
            endcase
            offer(REQ_SEED, pick, NO_AIM, '0);
         end else begin
            offer(REQ_GENERATE, ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0,
                  NO_AIM, '0);
         end
         items++;
         burst_left--;
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then give a stray result time to show up.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (board.fail_count == 0 && board.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
